// ----- rtl/ook_pulse_width_code_sender_assert.svh -----
// Assertion shorthands for the code sender, sampled on clock, quiet in reset.
`ifndef OOK_PULSE_WIDTH_CODE_SENDER_ASSERT_SVH
`define OOK_PULSE_WIDTH_CODE_SENDER_ASSERT_SVH

// Check a consequence in the same cycle.
`define OOKPWS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("code sender assertion failed");

// Check a consequence in the next cycle.
`define OOKPWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("code sender assertion failed");

`endif

// ----- rtl/ookpws_pkg.sv -----
`timescale 1ns / 1ps

package ookpws_pkg;

   // Configuration port
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int REPEAT_W    = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW_TIME  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW_TIME = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_GAP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_REPEATS = 3'd4;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] RST_BIT_PERIOD    = 16'd720;
   localparam logic [CSR_DATA_W-1:0] RST_ONE_LOW_TIME  = 16'd125;
   localparam logic [CSR_DATA_W-1:0] RST_ZERO_LOW_TIME = 16'd471;
   localparam logic [CSR_DATA_W-1:0] RST_FRAME_GAP     = 16'd5364;
   localparam logic [REPEAT_W-1:0]   RST_FRAME_REPEATS = 8'd12;

   // Input word function codes
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   // Result word
   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic done_res;
      logic start_rejected;
   } rsp_word_type;

endpackage

// ----- rtl/ookpws_cfg.sv -----
`timescale 1ns / 1ps

module ookpws_cfg #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [ookpws_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ookpws_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [TIME_WIDTH-1:0]                   hi_one,
   output logic [TIME_WIDTH-1:0]                   lo_one,
   output logic [TIME_WIDTH-1:0]                   hi_zero,
   output logic [TIME_WIDTH-1:0]                   lo_zero,
   output logic [TIME_WIDTH-1:0]                   gap_time,
   output logic [ookpws_pkg::REPEAT_W-1:0]         frame_repeats
);
   import ookpws_pkg::*;

   localparam logic [32:0] TIME_MAX = (33'd1 << TIME_WIDTH) - 33'd1;

   logic [CSR_DATA_W-1:0] bit_period_ff;
   logic [CSR_DATA_W-1:0] one_low_ff;
   logic [CSR_DATA_W-1:0] zero_low_ff;
   logic [CSR_DATA_W-1:0] gap_ff;
   logic [REPEAT_W-1:0]   repeats_ff;

   logic [CSR_DATA_W-1:0] hi_one_raw;
   logic [CSR_DATA_W-1:0] hi_zero_raw;

   logic [TIME_WIDTH-1:0] hi_one_ff, lo_one_ff, hi_zero_ff, lo_zero_ff, gap_time_ff;

   // Clamp a duration to the time counter range
   function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [CSR_DATA_W-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      sat_time = (wide > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0] : wide[TIME_WIDTH-1:0];
   endfunction

   // Write registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= RST_BIT_PERIOD;
         one_low_ff    <= RST_ONE_LOW_TIME;
         zero_low_ff   <= RST_ZERO_LOW_TIME;
         gap_ff        <= RST_FRAME_GAP;
         repeats_ff    <= RST_FRAME_REPEATS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIT_PERIOD:    bit_period_ff <= csr_wdata;
            CSR_ONE_LOW_TIME:  one_low_ff    <= csr_wdata;
            CSR_ZERO_LOW_TIME: zero_low_ff   <= csr_wdata;
            CSR_FRAME_GAP:     gap_ff        <= csr_wdata;
            CSR_FRAME_REPEATS: repeats_ff    <= csr_wdata[REPEAT_W-1:0];
            default: ;
         endcase
      end
   end

   // High time is what the low time leaves of the bit cell, floored at zero
   assign hi_one_raw  = (bit_period_ff > one_low_ff)  ? bit_period_ff - one_low_ff  : '0;
   assign hi_zero_raw = (bit_period_ff > zero_low_ff) ? bit_period_ff - zero_low_ff : '0;

   // Hold derived durations in registers
   always_ff @(posedge clock) begin
      hi_one_ff   <= sat_time(hi_one_raw);
      lo_one_ff   <= sat_time(one_low_ff);
      hi_zero_ff  <= sat_time(hi_zero_raw);
      lo_zero_ff  <= sat_time(zero_low_ff);
      gap_time_ff <= sat_time(gap_ff);
   end

   assign hi_one        = hi_one_ff;
   assign lo_one        = lo_one_ff;
   assign hi_zero       = hi_zero_ff;
   assign lo_zero       = lo_zero_ff;
   assign gap_time      = gap_time_ff;
   assign frame_repeats = repeats_ff;

endmodule

// ----- rtl/ookpws_core.sv -----
`timescale 1ns / 1ps

module ookpws_core #(
   parameter int CODE_BITS  = 25,
   parameter int TIME_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              func,
   input  logic [CODE_BITS-1:0]              code,
   input  logic [TIME_WIDTH-1:0]             hi_one,
   input  logic [TIME_WIDTH-1:0]             lo_one,
   input  logic [TIME_WIDTH-1:0]             hi_zero,
   input  logic [TIME_WIDTH-1:0]             lo_zero,
   input  logic [TIME_WIDTH-1:0]             gap_time,
   input  logic [ookpws_pkg::REPEAT_W-1:0]   frame_repeats,
   output ookpws_pkg::rsp_word_type          rsp_word
);
   import ookpws_pkg::*;

   localparam int POS_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

   typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_GAP} phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] time_left_ff, time_left_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [REPEAT_W-1:0]   frames_left_ff, frames_left_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;

   logic                  is_start;
   logic [CODE_BITS-1:0]  code_use;
   logic [CODE_BITS-1:0]  send_bits;
   logic [CODE_BITS-1:0]  cell_live;
   logic                  one_live, zero_live, gap_live;
   logic                  cur_bit;

   logic                  found_a, found_z;
   logic [POS_W-1:0]      pos_a, pos_z;
   phase_type             ent_a_phase, ent_z_phase;
   logic [TIME_WIDTH-1:0] ent_a_time, ent_z_time;

   logic [TIME_WIDTH-1:0] time_dec;
   logic [REPEAT_W-1:0]   frames_dec;

   assign is_start  = (func == FUNC_START);
   assign code_use  = is_start ? code : code_ff;
   assign one_live  = (hi_one != '0) || (lo_one != '0);
   assign zero_live = (hi_zero != '0) || (lo_zero != '0);
   assign gap_live  = (gap_time != '0);

   // Put bits in send order and mark cells that take any time
   always_comb begin
      for (int k = 0; k < CODE_BITS; k++) begin
         send_bits[k] = code_use[CODE_BITS-1-k];
         cell_live[k] = send_bits[k] ? one_live : zero_live;
      end
   end

   assign cur_bit = send_bits[pos_ff];

   // Find the first live cell after the current one, and the first in the frame
   always_comb begin
      found_a = 1'b0;
      pos_a   = '0;
      found_z = 1'b0;
      pos_z   = '0;
      for (int k = CODE_BITS - 1; k >= 0; k--) begin
         if (cell_live[k] && (k > int'(pos_ff))) begin
            found_a = 1'b1;
            pos_a   = POS_W'(k);
         end
         if (cell_live[k]) begin
            found_z = 1'b1;
            pos_z   = POS_W'(k);
         end
      end
   end

   // Entry phase of a found cell: high if it has high time, else straight to low
   always_comb begin
      if (send_bits[pos_a] ? (hi_one != '0) : (hi_zero != '0)) begin
         ent_a_phase = PH_HIGH;
         ent_a_time  = send_bits[pos_a] ? hi_one : hi_zero;
      end else begin
         ent_a_phase = PH_LOW;
         ent_a_time  = send_bits[pos_a] ? lo_one : lo_zero;
      end
      if (send_bits[pos_z] ? (hi_one != '0) : (hi_zero != '0)) begin
         ent_z_phase = PH_HIGH;
         ent_z_time  = send_bits[pos_z] ? hi_one : hi_zero;
      end else begin
         ent_z_phase = PH_LOW;
         ent_z_time  = send_bits[pos_z] ? lo_one : lo_zero;
      end
   end

   assign time_dec   = time_left_ff - 1'b1;
   assign frames_dec = frames_left_ff - 1'b1;

   // Next state and result word for one input word
   always_comb begin
      logic go_next_bit;
      logic go_frame_end;
      logic go_restart;

      phase_in       = phase_ff;
      time_left_in   = time_left_ff;
      pos_in         = pos_ff;
      frames_left_in = frames_left_ff;
      code_in        = code_ff;
      rsp_word       = '0;
      go_next_bit    = 1'b0;
      go_frame_end   = 1'b0;
      go_restart     = 1'b0;

      if (is_start) begin
         if (phase_ff != PH_IDLE) begin
            rsp_word.line_level     = (phase_ff == PH_HIGH);
            rsp_word.busy_res       = 1'b1;
            rsp_word.start_rejected = 1'b1;
         end else begin
            code_in        = code;
            frames_left_in = frame_repeats;
            if (frame_repeats == '0) begin
               rsp_word.done_res = 1'b1;
            end else begin
               go_restart = 1'b1;
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         rsp_word.line_level = (phase_ff == PH_HIGH);
         rsp_word.busy_res   = 1'b1;
         if (time_dec != '0) begin
            time_left_in = time_dec;
         end else begin
            case (phase_ff)
               PH_HIGH: begin
                  if ((cur_bit ? lo_one : lo_zero) != '0) begin
                     phase_in     = PH_LOW;
                     time_left_in = cur_bit ? lo_one : lo_zero;
                  end else begin
                     go_next_bit = 1'b1;
                  end
               end
               PH_LOW:  go_next_bit  = 1'b1;
               PH_GAP:  go_frame_end = 1'b1;
               default: ;
            endcase
         end
      end

      // Skip empty cells and an empty gap
      if (go_next_bit) begin
         if (found_a) begin
            phase_in     = ent_a_phase;
            time_left_in = ent_a_time;
            pos_in       = pos_a;
         end else if (gap_live) begin
            phase_in     = PH_GAP;
            time_left_in = gap_time;
         end else begin
            go_frame_end = 1'b1;
         end
      end

      // Count off a frame; finish or start over
      if (go_frame_end) begin
         if (frames_dec == '0) begin
            phase_in          = PH_IDLE;
            time_left_in      = '0;
            pos_in            = '0;
            frames_left_in    = '0;
            rsp_word.done_res = 1'b1;
         end else begin
            frames_left_in = frames_dec;
            go_restart     = 1'b1;
         end
      end

      // Start a frame at its first live cell or else its gap; with neither, finish
      if (go_restart) begin
         if (found_z) begin
            phase_in     = ent_z_phase;
            time_left_in = ent_z_time;
            pos_in       = pos_z;
         end else if (gap_live) begin
            phase_in     = PH_GAP;
            time_left_in = gap_time;
         end else begin
            phase_in          = PH_IDLE;
            time_left_in      = '0;
            pos_in            = '0;
            frames_left_in    = '0;
            rsp_word.done_res = 1'b1;
         end
      end

      if (is_start && (phase_ff == PH_IDLE)) begin
         rsp_word.busy_res = (phase_in != PH_IDLE);
      end
   end

   // Hold sender state; advance on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         time_left_ff   <= '0;
         pos_ff         <= '0;
         frames_left_ff <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         time_left_ff   <= time_left_in;
         pos_ff         <= pos_in;
         frames_left_ff <= frames_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         code_ff <= code_in;
      end
   end

endmodule

// ----- rtl/ook_pulse_width_code_sender.sv -----
`timescale 1ns / 1ps

// On-off keyed pulse-width code sender. A start word loads a CODE_BITS code
// that is sent first bit first, one bit cell per bit, each cell high then low
// by the one/zero low times, a low frame gap after every frame, the frame
// repeated frame_repeats times; every tick word moves the waveform by one tick
// and yields one result word with the pin level for that tick. One word is
// taken every cycle unless the result side stalls; its result passes through
// the input register and the result register around the single-pass sequencer
// next-state logic. Write the csr_ registers only while no word is in flight;
// a register change passes the csr register, then the duration register.
module ook_pulse_width_code_sender #(
   parameter int CODE_BITS  = 25,
   parameter int TIME_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [CODE_BITS-1:0]                 req_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_line_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic                                 rsp_start_rejected,
   input  logic                                 csr_we,
   input  logic [ookpws_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ookpws_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ookpws_pkg::*;

`include "ook_pulse_width_code_sender_assert.svh"

   logic                  in_valid_ff, in_valid_in;
   logic                  in_func_ff;
   logic [CODE_BITS-1:0]  in_code_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_word_type          out_word_ff;
   rsp_word_type          core_word;
   logic                  advance;
   logic                  fire;
   logic                  req_take;

   logic [TIME_WIDTH-1:0] hi_one, lo_one, hi_zero, lo_zero, gap_time;
   logic [REPEAT_W-1:0]   frame_repeats;

   // Handshake flow
   assign advance     = !out_valid_ff || rsp_ready;
   assign fire        = in_valid_ff && advance;
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_code_ff <= req_code;
      end
   end

   ookpws_cfg #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .hi_one        (hi_one),
      .lo_one        (lo_one),
      .hi_zero       (hi_zero),
      .lo_zero       (lo_zero),
      .gap_time      (gap_time),
      .frame_repeats (frame_repeats)
   );

   ookpws_core #(
      .CODE_BITS  (CODE_BITS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (fire),
      .func          (in_func_ff),
      .code          (in_code_ff),
      .hi_one        (hi_one),
      .lo_one        (lo_one),
      .hi_zero       (hi_zero),
      .lo_zero       (lo_zero),
      .gap_time      (gap_time),
      .frame_repeats (frame_repeats),
      .rsp_word      (core_word)
   );

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_word_ff <= core_word;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_line_level     = out_word_ff.line_level;
   assign rsp_busy_res       = out_word_ff.busy_res;
   assign rsp_done_res       = out_word_ff.done_res;
   assign rsp_start_rejected = out_word_ff.start_rejected;

   // A stalled result with a word waiting must block the input
   `OOKPWS_ASSERT_IMPLY(a_stall_blocks, in_valid_ff && out_valid_ff && !rsp_ready, !req_ready)
   // A processed word shows up as a result on the next cycle
   `OOKPWS_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid)
   // A rejected start only happens mid-code and never ends it
   `OOKPWS_ASSERT_IMPLY(a_rej_busy, rsp_valid && rsp_start_rejected, rsp_busy_res && !rsp_done_res)

endmodule
